// ----- hdl/zmp_pkg.sv -----
// Shared types, constants and saturating arithmetic for the ZMP preview tracker.
package zmp_pkg;

    // Default preview horizon in samples.
    localparam int PREVIEW_LEN_DEF = 256;

    // Field and port widths.
    localparam int FIX_W      = 48;
    localparam int COEF_W     = 47;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam int GIDX_W     = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DT            = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DT_SQ_HALF    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DT_CUBE_SIXTH = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_OVER_G = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GAIN    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_GAIN      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_GAIN      = 4'd7;

    // Request types.
    localparam logic REQ_LOAD_GAIN = 1'b0;
    localparam logic REQ_SAMPLE    = 1'b1;

    typedef logic signed [FIX_W-1:0] fix_t;
    typedef logic [COEF_W-1:0] coef_t;

    localparam fix_t FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

    // Multiply operations issued to the shared multiplier of each axis.
    typedef enum logic [3:0] {
        OP_HG_S2,
        OP_TAP,
        OP_GL_ERR,
        OP_GP_S0,
        OP_GV_S1,
        OP_GA_S2,
        OP_D1_S1,
        OP_D2_S2,
        OP_D3_U,
        OP_D1_S2,
        OP_D2_U,
        OP_D1_U
    } op_t;

    // What is done with a finished product.
    typedef enum logic [2:0] {
        ACT_ERR,
        ACT_PREV,
        ACT_U,
        ACT_N0,
        ACT_N1,
        ACT_N2
    } act_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic issue;
        op_t  op;
        logic load_wr;
        logic sample_wr;
        logic sub_prev;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic tap_last;
    } dp_status_t;

    function automatic act_t op_action(input op_t op);
        act_t act;
        unique case (op)
            OP_HG_S2:  act = ACT_ERR;
            OP_TAP:    act = ACT_PREV;
            OP_GL_ERR: act = ACT_U;
            OP_GP_S0:  act = ACT_U;
            OP_GV_S1:  act = ACT_U;
            OP_GA_S2:  act = ACT_U;
            OP_D1_S1:  act = ACT_N0;
            OP_D2_S2:  act = ACT_N0;
            OP_D3_U:   act = ACT_N0;
            OP_D1_S2:  act = ACT_N1;
            OP_D2_U:   act = ACT_N1;
            OP_D1_U:   act = ACT_N2;
            default:   act = ACT_PREV;
        endcase
        return act;
    endfunction

    // Products with a Q8.40 factor are shifted by 40, the others by 32.
    function automatic logic op_shift40(input op_t op);
        return (op == OP_HG_S2) || (op == OP_D1_S1) || (op == OP_D2_S2) ||
               (op == OP_D3_U) || (op == OP_D1_S2) || (op == OP_D2_U) ||
               (op == OP_D1_U);
    endfunction

    function automatic fix_t sat_add(input fix_t a, input fix_t b);
        logic signed [FIX_W:0] s;
        s = (FIX_W+1)'(a) + (FIX_W+1)'(b);
        if (s[FIX_W] != s[FIX_W-1])
            return s[FIX_W] ? FIX_MIN : FIX_MAX;
        return s[FIX_W-1:0];
    endfunction

    function automatic fix_t sat_sub(input fix_t a, input fix_t b);
        logic signed [FIX_W:0] s;
        s = (FIX_W+1)'(a) - (FIX_W+1)'(b);
        if (s[FIX_W] != s[FIX_W-1])
            return s[FIX_W] ? FIX_MIN : FIX_MAX;
        return s[FIX_W-1:0];
    endfunction

endpackage

// ----- hdl/zmp_if.sv -----
// Channel interfaces for request and result transactions.
interface zmp_in_if;
    import zmp_pkg::*;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [GIDX_W-1:0]   gain_index;
    fix_t                gain_value;
    fix_t                zmp_ref_x;
    fix_t                zmp_ref_y;

    modport source (output valid, req_type, gain_index, gain_value, zmp_ref_x, zmp_ref_y,
                    input ready);
    modport sink (input valid, req_type, gain_index, gain_value, zmp_ref_x, zmp_ref_y,
                  output ready);
endinterface

interface zmp_out_if;
    import zmp_pkg::*;
    logic valid;
    logic ready;
    fix_t com_pos_x;
    fix_t com_pos_y;
    fix_t com_vel_x;
    fix_t com_vel_y;
    fix_t com_acc_x;
    fix_t com_acc_y;

    modport source (output valid, com_pos_x, com_pos_y, com_vel_x, com_vel_y, com_acc_x,
                    com_acc_y, input ready);
    modport sink (input valid, com_pos_x, com_pos_y, com_vel_x, com_vel_y, com_acc_x,
                  com_acc_y, output ready);
endinterface

// ----- hdl/zmp_preview_com_tracker.sv -----
// A sample that completes the window gives its result after the height, tap, feedback and
// step phases, longer while the previous result still waits; load items and early samples
// finish in the cycle they are accepted. No new request is taken until the result is committed.
// The preview sum sets most of that time: it walks one gain-memory and one window-memory read
// per tap into a single multiplier per axis.
// Reset clears state, error sums, sample count and configuration; memories keep no reset.
// Top level of the ZMP preview center-of-mass tracker.
module zmp_preview_com_tracker
    import zmp_pkg::*;
#(
    parameter int PREVIEW_LEN = PREVIEW_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    zmp_in_if.sink                in_ch,
    zmp_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer for handshakes and multiply operations.
    zmp_ctrl #(
        .PREVIEW_LEN (PREVIEW_LEN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_req_type (in_ch.req_type),
        .in_ready    (in_ch.ready),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Arithmetic, memories and state.
    zmp_datapath #(
        .PREVIEW_LEN (PREVIEW_LEN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .gain_index (in_ch.gain_index),
        .gain_value (in_ch.gain_value),
        .zmp_ref_x  (in_ch.zmp_ref_x),
        .zmp_ref_y  (in_ch.zmp_ref_y),
        .cmd        (cmd),
        .status     (status),
        .com_pos_x  (out_ch.com_pos_x),
        .com_pos_y  (out_ch.com_pos_y),
        .com_vel_x  (out_ch.com_vel_x),
        .com_vel_y  (out_ch.com_vel_y),
        .com_acc_x  (out_ch.com_acc_x),
        .com_acc_y  (out_ch.com_acc_y)
    );

endmodule

// ----- hdl/zmp_ram.sv -----
// Generic simple dual-port RAM with a registered read.
module zmp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/zmp_mul.sv -----
// Pipelined 48x48 fixed-point multiplier with rounding shift and saturation.
module zmp_mul
    import zmp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  op_t  in_op,
    input  fix_t a,
    input  fix_t b,
    output logic out_valid,
    output op_t  out_op,
    output fix_t result,
    output logic busy
);

    localparam int HALF_W = FIX_W / 2;
    localparam int PROD_W = 2 * FIX_W;
    localparam logic [63:0] LIM_POS = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] LIM_NEG = 64'h0000_8000_0000_0000;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    op_t               op1_reg, op2_reg, op3_reg, op4_reg;
    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [FIX_W-1:0]  ma1_reg, mb1_reg;
    logic [FIX_W-1:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [PROD_W-1:0] prod3_reg;
    fix_t              res4_reg;
    logic [FIX_W-1:0]  ma_c, mb_c;
    logic [PROD_W-1:0] prod_c;
    logic [63:0]       mag_c;
    fix_t              res_c;

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 1: sign and magnitude of both factors.
    assign ma_c = a[FIX_W-1] ? (~a + 1'b1) : a;
    assign mb_c = b[FIX_W-1] ? (~b + 1'b1) : b;

    // Stage 3: sum of partial products plus the rounding half.
    always_comb
    begin
        prod_c = {{FIX_W{1'b0}}, pp_ll_reg}
               + ({{FIX_W{1'b0}}, pp_lh_reg} << HALF_W)
               + ({{FIX_W{1'b0}}, pp_hl_reg} << HALF_W)
               + {pp_hh_reg, {FIX_W{1'b0}}};
        prod_c = prod_c + (op_shift40(op2_reg) ? (PROD_W'(1) << 39) : (PROD_W'(1) << 31));
    end

    // Stage 4: shift, restore the sign and saturate.
    always_comb
    begin
        mag_c = op_shift40(op3_reg) ? 64'(prod3_reg >> 40) : 64'(prod3_reg >> 32);
        if (neg3_reg)
        begin
            res_c = (mag_c > LIM_NEG) ? FIX_MIN : fix_t'(~mag_c[FIX_W-1:0] + 1'b1);
        end
        else
        begin
            res_c = (mag_c > LIM_POS) ? FIX_MAX : fix_t'(mag_c[FIX_W-1:0]);
        end
    end

    // Payload pipeline.
    always_ff @(posedge clk)
    begin
        op1_reg   <= in_op;
        neg1_reg  <= a[FIX_W-1] ^ b[FIX_W-1];
        ma1_reg   <= ma_c;
        mb1_reg   <= mb_c;
        op2_reg   <= op1_reg;
        neg2_reg  <= neg1_reg;
        pp_ll_reg <= ma1_reg[HALF_W-1:0] * mb1_reg[HALF_W-1:0];
        pp_lh_reg <= ma1_reg[HALF_W-1:0] * mb1_reg[FIX_W-1:HALF_W];
        pp_hl_reg <= ma1_reg[FIX_W-1:HALF_W] * mb1_reg[HALF_W-1:0];
        pp_hh_reg <= ma1_reg[FIX_W-1:HALF_W] * mb1_reg[FIX_W-1:HALF_W];
        op3_reg   <= op2_reg;
        neg3_reg  <= neg2_reg;
        prod3_reg <= prod_c;
        op4_reg   <= op3_reg;
        res4_reg  <= res_c;
    end

    assign out_valid = v4_reg;
    assign out_op    = op4_reg;
    assign result    = res4_reg;
    assign busy      = v1_reg | v2_reg | v3_reg | v4_reg;

    // Every product that leaves has matching operands that entered the pipeline earlier.
    a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 4))
        else $error("multiplier result without matching operands");

endmodule

// ----- hdl/zmp_datapath.sv -----
// Datapath: configuration, gain and window memories, multipliers and state per axis.
module zmp_datapath
    import zmp_pkg::*;
#(
    parameter int PREVIEW_LEN = PREVIEW_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [GIDX_W-1:0]     gain_index,
    input  fix_t                  gain_value,
    input  fix_t                  zmp_ref_x,
    input  fix_t                  zmp_ref_y,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output fix_t                  com_pos_x,
    output fix_t                  com_pos_y,
    output fix_t                  com_vel_x,
    output fix_t                  com_vel_y,
    output fix_t                  com_acc_x,
    output fix_t                  com_acc_y
);

    localparam int WIN_LEN = PREVIEW_LEN + 1;
    localparam int IDXW    = $clog2(PREVIEW_LEN);
    localparam int WPW     = $clog2(WIN_LEN);

    coef_t           dt_reg, dt2_reg, dt3_reg, hg_reg;
    fix_t            gl_reg, gp_reg, gv_reg, ga_reg;
    logic [WPW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [WPW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [IDXW-1:0] tap_cnt_reg, tap_cnt_next;
    logic            d_valid_reg;
    op_t             d_op_reg;
    logic            gain_we;
    logic [FIX_W-1:0] gain_rdata;
    fix_t            ref_in [2];
    fix_t            pos_q [2];
    fix_t            vel_q [2];
    fix_t            acc_q [2];
    logic            mul_busy [2];

    function automatic logic [WPW-1:0] ptr_inc(input logic [WPW-1:0] p);
        return (p == WPW'(WIN_LEN - 1)) ? '0 : p + 1'b1;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg  <= '0;
            dt2_reg <= '0;
            dt3_reg <= '0;
            hg_reg  <= '0;
            gl_reg  <= '0;
            gp_reg  <= '0;
            gv_reg  <= '0;
            ga_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DT:            dt_reg  <= cfg_data[COEF_W-1:0];
                CFG_DT_SQ_HALF:    dt2_reg <= cfg_data[COEF_W-1:0];
                CFG_DT_CUBE_SIXTH: dt3_reg <= cfg_data[COEF_W-1:0];
                CFG_HEIGHT_OVER_G: hg_reg  <= cfg_data[COEF_W-1:0];
                CFG_ERROR_GAIN:    gl_reg  <= fix_t'(cfg_data);
                CFG_POS_GAIN:      gp_reg  <= fix_t'(cfg_data);
                CFG_VEL_GAIN:      gv_reg  <= fix_t'(cfg_data);
                CFG_ACC_GAIN:      ga_reg  <= fix_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // Window pointers and preview tap counter.
    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        tap_cnt_next = tap_cnt_reg;
        if (cmd.sample_wr)
        begin
            wr_ptr_next  = ptr_inc(wr_ptr_reg);
            rd_ptr_next  = ptr_inc(wr_ptr_reg);
            tap_cnt_next = '0;
        end
        else if (cmd.issue && (cmd.op == OP_HG_S2 || cmd.op == OP_TAP))
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            if (cmd.op == OP_TAP)
            begin
                tap_cnt_next = tap_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            tap_cnt_reg <= '0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            tap_cnt_reg <= tap_cnt_next;
            d_valid_reg <= cmd.issue;
        end
    end

    // Operation code is registered alongside the memory read, so it arrives with the read data.
    always_ff @(posedge clk)
    begin
        d_op_reg <= cmd.op;
    end

    // Preview gain memory.
    assign gain_we = cmd.load_wr && (32'(gain_index) < 32'(PREVIEW_LEN));

    zmp_ram #(
        .WIDTH (FIX_W),
        .DEPTH (PREVIEW_LEN)
    ) u_gain_ram (
        .clk   (clk),
        .we    (gain_we),
        .waddr (IDXW'(gain_index)),
        .wdata (gain_value),
        .raddr (tap_cnt_reg),
        .rdata (gain_rdata)
    );

    assign ref_in[0] = zmp_ref_x;
    assign ref_in[1] = zmp_ref_y;

    // One window memory, multiplier and state set per axis.
    for (genvar g = 0; g < 2; g++)
    begin : g_axis
        logic [FIX_W-1:0] win_rdata;
        fix_t pos_reg, vel_reg, acc_reg, err_reg;
        fix_t pos_next, vel_next, acc_next, err_next;
        fix_t prev_reg, u_reg, n0_reg, n1_reg, n2_reg, win0_reg;
        fix_t prev_next, u_next, n0_next, n1_next, n2_next, win0_next;
        fix_t opa, opb, m_res;
        logic m_valid;
        op_t  m_op;

        zmp_ram #(
            .WIDTH (FIX_W),
            .DEPTH (WIN_LEN)
        ) u_win_ram (
            .clk   (clk),
            .we    (cmd.sample_wr),
            .waddr (wr_ptr_reg),
            .wdata (ref_in[g]),
            .raddr (rd_ptr_reg),
            .rdata (win_rdata)
        );

        // Operand selection for the issued operation.
        always_comb
        begin
            unique case (d_op_reg)
                OP_HG_S2:  begin opa = fix_t'({1'b0, hg_reg});  opb = acc_reg; end
                OP_TAP:    begin opa = fix_t'(gain_rdata);       opb = fix_t'(win_rdata); end
                OP_GL_ERR: begin opa = gl_reg;                   opb = err_reg; end
                OP_GP_S0:  begin opa = gp_reg;                   opb = pos_reg; end
                OP_GV_S1:  begin opa = gv_reg;                   opb = vel_reg; end
                OP_GA_S2:  begin opa = ga_reg;                   opb = acc_reg; end
                OP_D1_S1:  begin opa = fix_t'({1'b0, dt_reg});  opb = vel_reg; end
                OP_D2_S2:  begin opa = fix_t'({1'b0, dt2_reg}); opb = acc_reg; end
                OP_D3_U:   begin opa = fix_t'({1'b0, dt3_reg}); opb = u_reg; end
                OP_D1_S2:  begin opa = fix_t'({1'b0, dt_reg});  opb = acc_reg; end
                OP_D2_U:   begin opa = fix_t'({1'b0, dt2_reg}); opb = u_reg; end
                OP_D1_U:   begin opa = fix_t'({1'b0, dt_reg});  opb = u_reg; end
                default:   begin opa = fix_t'(gain_rdata);       opb = fix_t'(win_rdata); end
            endcase
        end

        zmp_mul u_mul (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (d_valid_reg),
            .in_op     (d_op_reg),
            .a         (opa),
            .b         (opb),
            .out_valid (m_valid),
            .out_op    (m_op),
            .result    (m_res),
            .busy      (mul_busy[g])
        );

        // Accumulation of products and the state update.
        always_comb
        begin
            pos_next  = pos_reg;
            vel_next  = vel_reg;
            acc_next  = acc_reg;
            err_next  = err_reg;
            prev_next = prev_reg;
            u_next    = u_reg;
            n0_next   = n0_reg;
            n1_next   = n1_reg;
            n2_next   = n2_reg;
            win0_next = win0_reg;
            if (d_valid_reg && d_op_reg == OP_HG_S2)
            begin
                win0_next = fix_t'(win_rdata);
            end
            if (cmd.sample_wr)
            begin
                prev_next = '0;
                u_next    = '0;
                n0_next   = pos_reg;
                n1_next   = vel_reg;
                n2_next   = acc_reg;
            end
            if (cmd.sub_prev)
            begin
                u_next = sat_sub(u_reg, prev_reg);
            end
            if (cmd.commit)
            begin
                pos_next = n0_reg;
                vel_next = n1_reg;
                acc_next = n2_reg;
            end
            if (m_valid)
            begin
                unique case (op_action(m_op))
                    ACT_ERR:  err_next  = sat_add(err_reg,
                                          sat_sub(sat_sub(pos_reg, m_res), win0_reg));
                    ACT_PREV: prev_next = sat_add(prev_reg, m_res);
                    ACT_U:    u_next    = sat_sub(u_reg, m_res);
                    ACT_N0:   n0_next   = sat_add(n0_reg, m_res);
                    ACT_N1:   n1_next   = sat_add(n1_reg, m_res);
                    ACT_N2:   n2_next   = sat_add(n2_reg, m_res);
                    default: ;
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pos_reg <= '0;
                vel_reg <= '0;
                acc_reg <= '0;
                err_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                vel_reg <= vel_next;
                acc_reg <= acc_next;
                err_reg <= err_next;
            end
        end

        always_ff @(posedge clk)
        begin
            prev_reg <= prev_next;
            u_reg    <= u_next;
            n0_reg   <= n0_next;
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            win0_reg <= win0_next;
        end

        assign pos_q[g] = pos_reg;
        assign vel_q[g] = vel_reg;
        assign acc_q[g] = acc_reg;
    end

    assign status.busy     = d_valid_reg | mul_busy[0] | mul_busy[1];
    assign status.tap_last = (tap_cnt_reg == IDXW'(PREVIEW_LEN - 1));

    assign com_pos_x = pos_q[0];
    assign com_pos_y = pos_q[1];
    assign com_vel_x = vel_q[0];
    assign com_vel_y = vel_q[1];
    assign com_acc_x = acc_q[0];
    assign com_acc_y = acc_q[1];

endmodule

// ----- hdl/zmp_ctrl.sv -----
// Controller: handshakes and the sequence of multiply operations for one sample.
module zmp_ctrl
    import zmp_pkg::*;
#(
    parameter int PREVIEW_LEN = PREVIEW_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_req_type,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int WIN_LEN = PREVIEW_LEN + 1;
    localparam int SW      = $clog2(WIN_LEN + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HG     = 4'd1;
    localparam logic [3:0] ST_TAP    = 4'd2;
    localparam logic [3:0] ST_DRAIN1 = 4'd3;
    localparam logic [3:0] ST_FB     = 4'd4;
    localparam logic [3:0] ST_DRAIN2 = 4'd5;
    localparam logic [3:0] ST_UPREV  = 4'd6;
    localparam logic [3:0] ST_STEP   = 4'd7;
    localparam logic [3:0] ST_DRAIN3 = 4'd8;
    localparam logic [3:0] ST_COMMIT = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [SW-1:0] samples_reg, samples_next;
    logic          out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        samples_next   = samples_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.op         = OP_TAP;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_req_type == REQ_LOAD_GAIN)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.sample_wr = 1'b1;
                        if (samples_reg != SW'(WIN_LEN))
                        begin
                            samples_next = samples_reg + 1'b1;
                        end
                        if (samples_reg >= SW'(WIN_LEN - 1))
                        begin
                            state_next = ST_HG;
                        end
                    end
                end
            end
            ST_HG:
            begin
                cmd.issue  = 1'b1;
                cmd.op     = OP_HG_S2;
                state_next = ST_TAP;
            end
            ST_TAP:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_TAP;
                if (status.tap_last)
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1:
            begin
                if (!status.busy)
                begin
                    state_next = ST_FB;
                    cnt_next   = '0;
                end
            end
            ST_FB:
            begin
                cmd.issue = 1'b1;
                unique case (cnt_reg)
                    3'd0:    cmd.op = OP_GL_ERR;
                    3'd1:    cmd.op = OP_GP_S0;
                    3'd2:    cmd.op = OP_GV_S1;
                    default: cmd.op = OP_GA_S2;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd3)
                begin
                    state_next = ST_DRAIN2;
                end
            end
            ST_DRAIN2:
            begin
                if (!status.busy)
                begin
                    state_next = ST_UPREV;
                end
            end
            ST_UPREV:
            begin
                cmd.sub_prev = 1'b1;
                state_next   = ST_STEP;
                cnt_next     = '0;
            end
            ST_STEP:
            begin
                cmd.issue = 1'b1;
                unique case (cnt_reg)
                    3'd0:    cmd.op = OP_D1_S1;
                    3'd1:    cmd.op = OP_D2_S2;
                    3'd2:    cmd.op = OP_D3_U;
                    3'd3:    cmd.op = OP_D1_S2;
                    3'd4:    cmd.op = OP_D2_U;
                    default: cmd.op = OP_D1_U;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd5)
                begin
                    state_next = ST_DRAIN3;
                end
            end
            ST_DRAIN3:
            begin
                if (!status.busy)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            samples_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            samples_reg   <= samples_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // The state is only overwritten once the previous result has been taken.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before its transaction");

    // Multiplies are only issued while a sample is being worked on.
    a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (state_reg != ST_IDLE && !in_ready))
        else $error("multiply issued while accepting requests");

    // A result only follows once the window has filled.
    a_result_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (samples_reg == SW'(WIN_LEN)))
        else $error("result before the window filled");

endmodule

// ----- tb/zmp_tracker_checker.sv -----
// Checker for the ZMP preview tracker: predicts every result and compares it on the output channel.
`timescale 1ns / 1ps

module zmp_tracker_checker
    import zmp_pkg::*;
#(
    parameter int PLEN = PREVIEW_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    zmp_in_if                     in_ch,
    zmp_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fails,
    output int                    pending
);

    typedef struct packed {
        fix_t pos_x;
        fix_t pos_y;
        fix_t vel_x;
        fix_t vel_y;
        fix_t acc_x;
        fix_t acc_y;
    } com_state_t;

    // Expected CoM states, oldest first.
    com_state_t com_queue[$];

    // Mirror of the configuration registers.
    coef_t dt_q, dt2_q, dt3_q, hg_q;
    fix_t  gl_q, gp_q, gv_q, ga_q;

    // Mirror of the tracker state; axis 0 is x, axis 1 is y.
    fix_t preview_gain [PLEN];
    fix_t zmp_win [2][PLEN+1];
    fix_t com_st [2][3];
    fix_t err_sum [2];
    int   samples_in;

    function automatic fix_t sat_sum(input fix_t a, input fix_t b);
        logic signed [FIX_W:0] s;
        s = a + b;
        if (s > FIX_MAX)
            return FIX_MAX;
        if (s < FIX_MIN)
            return FIX_MIN;
        return s[FIX_W-1:0];
    endfunction

    function automatic fix_t sat_diff(input fix_t a, input fix_t b);
        logic signed [FIX_W:0] s;
        s = a - b;
        if (s > FIX_MAX)
            return FIX_MAX;
        if (s < FIX_MIN)
            return FIX_MIN;
        return s[FIX_W-1:0];
    endfunction

    // Exact product, rounded to nearest with ties away from zero, then saturated.
    function automatic fix_t scaled_product(input logic signed [FIX_W:0] a,
                                            input logic signed [FIX_W:0] b, input int sh);
        logic signed [97:0] prod;
        logic [97:0]        mag;
        logic               neg;
        prod = a * b;
        neg  = prod < 0;
        mag  = neg ? -prod : prod;
        mag  = (mag + (98'd1 << (sh - 1))) >> sh;
        if (neg)
        begin
            if (mag > 98'h8000_0000_0000)
                return FIX_MIN;
            return fix_t'(-mag);
        end
        if (mag > 98'h7FFF_FFFF_FFFF)
            return FIX_MAX;
        return fix_t'(mag);
    endfunction

    // One control step of one axis: error integration, preview sum, jerk, state update.
    task automatic advance_axis(input int ax);
        fix_t zmp, tap_sum, jerk, n0, n1, n2;
        zmp = sat_diff(com_st[ax][0], scaled_product(hg_q, com_st[ax][2], 40));
        err_sum[ax] = sat_sum(err_sum[ax], sat_diff(zmp, zmp_win[ax][0]));
        tap_sum = '0;
        for (int j = 0; j < PLEN; j++)
            tap_sum = sat_sum(tap_sum, scaled_product(preview_gain[j], zmp_win[ax][j+1], 32));
        jerk = '0;
        jerk = sat_diff(jerk, scaled_product(gl_q, err_sum[ax], 32));
        jerk = sat_diff(jerk, scaled_product(gp_q, com_st[ax][0], 32));
        jerk = sat_diff(jerk, scaled_product(gv_q, com_st[ax][1], 32));
        jerk = sat_diff(jerk, scaled_product(ga_q, com_st[ax][2], 32));
        jerk = sat_diff(jerk, tap_sum);
        n0 = sat_sum(com_st[ax][0], scaled_product(dt_q, com_st[ax][1], 40));
        n0 = sat_sum(n0, scaled_product(dt2_q, com_st[ax][2], 40));
        n0 = sat_sum(n0, scaled_product(dt3_q, jerk, 40));
        n1 = sat_sum(com_st[ax][1], scaled_product(dt_q, com_st[ax][2], 40));
        n1 = sat_sum(n1, scaled_product(dt2_q, jerk, 40));
        n2 = sat_sum(com_st[ax][2], scaled_product(dt_q, jerk, 40));
        com_st[ax][0] = n0;
        com_st[ax][1] = n1;
        com_st[ax][2] = n2;
    endtask

    task automatic report_mismatch(input string what, input fix_t got, input fix_t want);
        $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            {dt_q, dt2_q, dt3_q, hg_q} = '0;
            {gl_q, gp_q, gv_q, ga_q} = '0;
            com_st     = '{default: '0};
            err_sum    = '{default: '0};
            samples_in = 0;
            fails      = 0;
            com_queue.delete();
            pending    = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DT:            dt_q  = cfg_data[COEF_W-1:0];
                    CFG_DT_SQ_HALF:    dt2_q = cfg_data[COEF_W-1:0];
                    CFG_DT_CUBE_SIXTH: dt3_q = cfg_data[COEF_W-1:0];
                    CFG_HEIGHT_OVER_G: hg_q  = cfg_data[COEF_W-1:0];
                    CFG_ERROR_GAIN:    gl_q  = cfg_data;
                    CFG_POS_GAIN:      gp_q  = cfg_data;
                    CFG_VEL_GAIN:      gv_q  = cfg_data;
                    CFG_ACC_GAIN:      ga_q  = cfg_data;
                    default: ;
                endcase
            end

            // Compare each result transaction with the oldest expectation.
            if (out_ch.valid && out_ch.ready)
            begin
                if (com_queue.size() == 0)
                    report_mismatch("unexpected result", out_ch.com_pos_x, '0);
                else
                begin
                    com_state_t want;
                    want = com_queue.pop_front();
                    if (out_ch.com_pos_x !== want.pos_x)
                        report_mismatch("com_pos_x", out_ch.com_pos_x, want.pos_x);
                    if (out_ch.com_pos_y !== want.pos_y)
                        report_mismatch("com_pos_y", out_ch.com_pos_y, want.pos_y);
                    if (out_ch.com_vel_x !== want.vel_x)
                        report_mismatch("com_vel_x", out_ch.com_vel_x, want.vel_x);
                    if (out_ch.com_vel_y !== want.vel_y)
                        report_mismatch("com_vel_y", out_ch.com_vel_y, want.vel_y);
                    if (out_ch.com_acc_x !== want.acc_x)
                        report_mismatch("com_acc_x", out_ch.com_acc_x, want.acc_x);
                    if (out_ch.com_acc_y !== want.acc_y)
                        report_mismatch("com_acc_y", out_ch.com_acc_y, want.acc_y);
                end
            end

            // Predict from each request transaction.
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.req_type == REQ_LOAD_GAIN)
                begin
                    if (int'(in_ch.gain_index) < PLEN)
                        preview_gain[in_ch.gain_index] = in_ch.gain_value;
                end
                else
                begin
                    for (int j = 0; j < PLEN; j++)
                    begin
                        zmp_win[0][j] = zmp_win[0][j+1];
                        zmp_win[1][j] = zmp_win[1][j+1];
                    end
                    zmp_win[0][PLEN] = in_ch.zmp_ref_x;
                    zmp_win[1][PLEN] = in_ch.zmp_ref_y;
                    if (samples_in < PLEN + 1)
                        samples_in++;
                    if (samples_in == PLEN + 1)
                    begin
                        advance_axis(0);
                        advance_axis(1);
                        com_queue.insert(com_queue.size(),
                                         com_state_t'{com_st[0][0], com_st[1][0], com_st[0][1],
                                                      com_st[1][1], com_st[0][2],
                                                      com_st[1][2]});
                    end
                end
            end
            pending = com_queue.size();
        end
    end

endmodule

// ----- tb/tb_zmp_preview_com_tracker.sv -----
// Top of the ZMP preview tracker testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_zmp_preview_com_tracker;
    import zmp_pkg::*;

    localparam int PLEN      = PREVIEW_LEN_DEF;
    localparam int DRAIN     = PLEN + 48;
    localparam int IDLE_MAX  = 20000;
    localparam int HOLD_LEN  = 3000;
    localparam int PHASES    = 5;
    localparam int PHASE_LEN = 240;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fails;
    int pending;
    int results_seen;
    int idle_cycles;
    int burst_left;

    zmp_in_if  in_ch ();
    zmp_out_if out_ch ();

    zmp_preview_com_tracker #(.PREVIEW_LEN(PLEN)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    zmp_tracker_checker #(.PLEN(PLEN)) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog on cycles without any transaction; also counts results for the receiver.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (out_ch.valid && out_ch.ready)
            results_seen <= results_seen + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Signed random value of the given width, sign-extended to the field width.
    function automatic fix_t rnd_small(input int bits);
        logic signed [63:0] r;
        r = {$urandom, $urandom};
        r = r >>> (64 - bits);
        return fix_t'(r);
    endfunction

    // Field value: mostly moderate, sometimes full range or an extreme.
    function automatic fix_t rnd_field(input int bits);
        case ($urandom_range(0, 15))
            0:       return FIX_MAX;
            1:       return FIX_MIN;
            2, 3:    return fix_t'({$urandom, $urandom});
            default: return rnd_small(bits);
        endcase
    endfunction

    // Offer one request transaction and wait until it is accepted; idle between bursts.
    task automatic send_req(input logic rt, input logic [GIDX_W-1:0] gi, input fix_t gv,
                            input fix_t zx, input fix_t zy);
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= rt;
        in_ch.gain_index <= gi;
        in_ch.gain_value <= gv;
        in_ch.zmp_ref_x  <= zx;
        in_ch.zmp_ref_y  <= zy;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 48);
        end
    endtask

    // Stop offering and let every expected result drain before touching registers.
    task automatic wait_idle();
        if (in_ch.valid)
            in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] d1, d2, d3, hg, gl, gp, gv, ga);
        put_reg(CFG_DT, d1);
        put_reg(CFG_DT_SQ_HALF, d2);
        put_reg(CFG_DT_CUBE_SIXTH, d3);
        put_reg(CFG_HEIGHT_OVER_G, hg);
        put_reg(CFG_ERROR_GAIN, gl);
        put_reg(CFG_POS_GAIN, gp);
        put_reg(CFG_VEL_GAIN, gv);
        put_reg(CFG_ACC_GAIN, ga);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random ready patterns, plus one long hold-off once results flow.
    initial
    begin
        int mode;
        int mode_left;
        bit held;
        mode_left = 0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= 40)
            begin
                out_ch.ready <= 1'b0;
                held = 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 400);
            end
            case (mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
            mode_left--;
            @(posedge clk);
        end
    end

    // Stimulus.
    initial
    begin
        in_ch.valid      <= 1'b0;
        in_ch.req_type   <= REQ_LOAD_GAIN;
        in_ch.gain_index <= '0;
        in_ch.gain_value <= '0;
        in_ch.zmp_ref_x  <= '0;
        in_ch.zmp_ref_y  <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        results_seen     <= 0;
        idle_cycles      <= 0;
        burst_left       = 20;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Typical walking parameters: 5 ms period, 0.8 m CoM height.
        set_config(48'd5497558139, 48'd13743895, 48'd22906, 48'd89664380000,
                   rnd_small(34), rnd_small(36), rnd_small(34), rnd_small(30));

        // Every preview gain is loaded before the window can fill.
        for (int i = 0; i < PLEN; i++)
            send_req(REQ_LOAD_GAIN, GIDX_W'(i), rnd_small(24), rnd_field(36), rnd_field(36));
        for (int i = 0; i < PLEN + 1; i++)
            send_req(REQ_SAMPLE, GIDX_W'($urandom), rnd_small(24), rnd_small(36), rnd_small(36));

        // Directed: extreme references and extreme gains at both ends of the table.
        send_req(REQ_SAMPLE, '0, '0, FIX_MAX, FIX_MIN);
        send_req(REQ_SAMPLE, '0, '0, FIX_MIN, FIX_MAX);
        send_req(REQ_SAMPLE, '1, '0, '0, '0);
        send_req(REQ_LOAD_GAIN, GIDX_W'(PLEN - 1), FIX_MAX, '0, '0);
        send_req(REQ_LOAD_GAIN, '0, FIX_MIN, '0, '0);
        send_req(REQ_SAMPLE, '0, '0, rnd_small(36), rnd_small(36));
        send_req(REQ_LOAD_GAIN, GIDX_W'(PLEN - 1), rnd_small(24), '0, '0);
        send_req(REQ_LOAD_GAIN, '0, rnd_small(24), '0, '0);
        send_req(REQ_SAMPLE, '0, '0, FIX_MAX, FIX_MAX);
        send_req(REQ_SAMPLE, '0, '0, FIX_MIN, FIX_MIN);
        send_req(REQ_SAMPLE, '0, '0, '0, '0);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_config(48'd5497558139, 48'd13743895, 48'd22906, 48'd89664380000,
                              rnd_small(36), rnd_small(38), rnd_small(36), rnd_small(32));
                1: set_config('1, '1, '1, '1, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
                2: set_config('0, '0, '0, '0, '0, '0, '0, '0);
                3: set_config(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                              48'h7FFF_FFFF_FFFF, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
                default: set_config({$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if ($urandom_range(0, 9) < 2)
                    send_req(REQ_LOAD_GAIN, GIDX_W'($urandom), rnd_field(24),
                             rnd_field(36), rnd_field(36));
                else
                    send_req(REQ_SAMPLE, GIDX_W'($urandom), rnd_field(24),
                             rnd_field(36), rnd_field(36));
            end
        end

        // Drain and give the verdict.
        wait_idle();
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/zmp_pkg.sv
hdl/zmp_if.sv
hdl/zmp_ram.sv
hdl/zmp_mul.sv
hdl/zmp_datapath.sv
hdl/zmp_ctrl.sv
hdl/zmp_preview_com_tracker.sv
tb/zmp_tracker_checker.sv
tb/tb_zmp_preview_com_tracker.sv
